>>> sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int OFF_W = 28;
    localparam int SZ_W  = 29;
    localparam int ST_W  = 3;

    localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_MEM    = 3'd2;
    localparam logic [ST_W-1:0] ST_TBL_FULL  = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_BLOCK  = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [31:0] HEAP_SPAN  = 32'h1000_0000;
    localparam logic [29:0] ALIGN_MASK = 30'd15;

    typedef struct packed {
        logic            free;
        logic [SZ_W-1:0]  size;
        logic [OFF_W-1:0] offset;
    } t_entry;

endpackage

>>> sv/ffha_table.sv
// ----------------------------------------------------------------------------
// ffha_table
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_table #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  ffha_pkg::t_entry         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output ffha_pkg::t_entry         o_rd_data
);
    import ffha_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

>>> sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Allocate reads and evaluates each block scanned, plus a read and a write per entry
// shifted on a split; free reads and evaluates each block scanned, then runs a merge
// pass over every table entry. Both are bound by the single block table memory port pair.
// One transaction in work at a time; a result may wait while the next is taken.
// Reset (synchronous) rewrites entry zero in one cycle before input is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [16:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // request_bytes[28:0], release_offset[56:29]
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // status[2:0], payload_offset[30:3],
                                       // granted_bytes[59:31]
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PG = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [31:0]   HDR  = 32'(HEADER_BYTES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SHIFT_RD, S_SHIFT_WR,
        S_SPLIT_WR, S_GRANT_WR, S_CMP_RD, S_CMP_EV, S_RESULT
    } t_state;

    t_state          r_state;
    logic            r_op;
    logic [29:0]     r_need;
    logic [OFF_W-1:0] r_rel;
    logic [CW-1:0]   r_cnt, r_idx, r_k, r_w;
    logic [SZ_W-1:0] r_mapped;
    logic [16:0]     r_limit;
    t_entry          r_hit, r_cur;
    logic            r_have;
    logic [ST_W-1:0]  r_st;
    logic [OFF_W-1:0] r_res_off;
    logic [SZ_W-1:0]  r_res_sz;
    logic            r_out_valid;
    logic [63:0]     r_out_data;

    logic            wr_en;
    logic [IW-1:0]   wr_addr, rd_addr;
    t_entry          wr_data, rd_data, ev;
    logic [31:0]     grow_total, grow_sum;
    logic            grow_bad;
    logic [29:0]     req_need;

    ffha_table #(.DEPTH(MAX_BLOCKS)) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign req_need   = ({1'b0, s_axis_tdata[28:0]} + ALIGN_MASK) & ~ALIGN_MASK;
    assign grow_total = ((32'(r_need) + HDR + 32'(PAGE_BYTES - 1)) >> PG) << PG;
    assign grow_sum   = 32'(r_mapped) + grow_total;
    assign grow_bad   = (grow_sum > HEAP_SPAN) || ((grow_sum >> PG) > 32'(r_limit));

    always_comb begin
        ev = rd_data;
        if (r_op == OP_FREE && r_idx == r_k) begin
            ev.free = 1'b1;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[IW-1:0];
        wr_data = r_hit;
        rd_addr = r_idx[IW-1:0];
        case (r_state)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '{free: 1'b1, size: SZ_W'(PAGE_BYTES - HEADER_BYTES),
                            offset: '0};
            end
            S_SCAN_RD: begin
                if (r_idx == r_cnt && r_op == OP_ALLOC && !grow_bad && r_cnt < MAXC) begin
                    wr_en   = 1'b1;
                    wr_addr = r_cnt[IW-1:0];
                    wr_data = '{free: 1'b0, size: SZ_W'(grow_total - HDR),
                                offset: r_mapped[OFF_W-1:0]};
                end
            end
            S_SHIFT_RD: rd_addr = IW'(r_k - 1'b1);
            S_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_k[IW-1:0];
                wr_data = rd_data;
            end
            S_SPLIT_WR: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_idx + 1'b1);
                wr_data = '{free: 1'b1,
                            size: r_hit.size - r_need[SZ_W-1:0] - SZ_W'(HEADER_BYTES),
                            offset: r_hit.offset + OFF_W'(HEADER_BYTES)
                                    + r_need[OFF_W-1:0]};
            end
            S_GRANT_WR: begin
                wr_en   = 1'b1;
                wr_data = '{free: 1'b0, size: r_hit.size, offset: r_hit.offset};
            end
            S_CMP_RD: begin
                if (r_idx == r_cnt) begin
                    wr_en   = 1'b1;
                    wr_addr = r_w[IW-1:0];
                    wr_data = r_cur;
                end
            end
            S_CMP_EV: begin
                if (r_have && !(r_cur.free && ev.free)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_w[IW-1:0];
                    wr_data = r_cur;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= CW'(1);
            r_mapped    <= SZ_W'(PAGE_BYTES);
            r_limit     <= 17'h10000;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (r_out_valid && m_axis_tready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op      <= s_axis_tuser;
                        r_need    <= req_need;
                        r_rel     <= s_axis_tdata[56:29];
                        r_idx     <= '0;
                        r_res_off <= '0;
                        r_res_sz  <= '0;
                        if (s_axis_tuser == OP_ALLOC && s_axis_tdata[28:0] == '0) begin
                            r_st    <= ST_ZERO_SIZE;
                            r_state <= S_RESULT;
                        end else begin
                            r_st    <= ST_DONE;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: begin
                    if (r_idx == r_cnt) begin
                        r_state <= S_RESULT;
                        if (r_op == OP_FREE) begin
                            r_st <= ST_NO_BLOCK;
                        end else if (grow_bad) begin
                            r_st <= ST_NO_MEM;
                        end else if (r_cnt >= MAXC) begin
                            r_st <= ST_TBL_FULL;
                        end else begin
                            r_cnt     <= r_cnt + 1'b1;
                            r_mapped  <= grow_sum[SZ_W-1:0];
                            r_res_off <= r_mapped[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
                            r_res_sz  <= SZ_W'(grow_total - HDR);
                        end
                    end else begin
                        r_state <= S_SCAN_EV;
                    end
                end
                S_SCAN_EV: begin
                    r_hit <= rd_data;
                    if (r_op == OP_ALLOC) begin
                        r_k <= r_cnt;
                        if (rd_data.free && {1'b0, rd_data.size} >= r_need) begin
                            if ({2'b0, rd_data.size} > 32'(r_need) + HDR && r_cnt < MAXC) begin
                                r_state <= S_SHIFT_RD;
                            end else begin
                                r_state <= S_GRANT_WR;
                            end
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN_RD;
                        end
                    end else begin
                        if (32'(rd_data.offset) + HDR == 32'(r_rel)) begin
                            r_k     <= r_idx;
                            r_idx   <= '0;
                            r_w     <= '0;
                            r_have  <= 1'b0;
                            r_state <= S_CMP_RD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SHIFT_RD: begin
                    if (r_k > r_idx + 1'b1) begin
                        r_state <= S_SHIFT_WR;
                    end else begin
                        r_state <= S_SPLIT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_k     <= r_k - 1'b1;
                    r_state <= S_SHIFT_RD;
                end
                S_SPLIT_WR: begin
                    r_cnt      <= r_cnt + 1'b1;
                    r_hit.size <= r_need[SZ_W-1:0];
                    r_state    <= S_GRANT_WR;
                end
                S_GRANT_WR: begin
                    r_res_off <= r_hit.offset + OFF_W'(HEADER_BYTES);
                    r_res_sz  <= r_hit.size;
                    r_state   <= S_RESULT;
                end
                S_CMP_RD: begin
                    if (r_idx == r_cnt) begin
                        r_cnt   <= r_w + 1'b1;
                        r_state <= S_RESULT;
                    end else begin
                        r_state <= S_CMP_EV;
                    end
                end
                S_CMP_EV: begin
                    r_have <= 1'b1;
                    if (!r_have) begin
                        r_cur <= ev;
                    end else if (r_cur.free && ev.free) begin
                        r_cur.size <= r_cur.size + SZ_W'(HEADER_BYTES) + ev.size;
                    end else begin
                        r_w   <= r_w + 1'b1;
                        r_cur <= ev;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_CMP_RD;
                end
                S_RESULT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'b0, r_res_sz, r_res_off, r_st};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
